@@ rtl/cpps_pkg.sv @@
// ----------------------------------------------------------------------------
// cpps_pkg
// Shared types, codes and fixed-point helpers of the contact position solver.
// ----------------------------------------------------------------------------
package cpps_pkg;

   localparam int CPPS_MAX_BODIES      = 64;
   localparam int CPPS_MAX_CONSTRAINTS = 64;

   localparam int COMP_W = 21;          // one Q8.12 vector component
   localparam int VEC_W  = 3 * COMP_W;  // x, y, z packed, x lowest

   // reset values of the control registers
   localparam logic [30:0] SLOP_RESET       = 31'd328;
   localparam logic [4:0]  ITERATIONS_RESET = 5'd8;
   localparam logic [6:0]  CCOUNT_RESET     = 7'd0;
   localparam logic [6:0]  BCOUNT_RESET     = 7'd64;

   typedef enum logic [1:0] {
      ACT_LOAD_BODY = 2'd0,
      ACT_LOAD_CST  = 2'd1,
      ACT_SOLVE     = 2'd2,
      ACT_READ      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_SLOP       = 3'd0,
      REG_ITERATIONS = 3'd1,
      REG_CCOUNT     = 3'd2,
      REG_BCOUNT     = 3'd3,
      REG_ASLEEP     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [30:0]      inverse_mass;
      logic [VEC_W-1:0] inertia;
   } body_word_type;

   typedef struct packed {
      logic [VEC_W-1:0] ang;
      logic [VEC_W-1:0] lin;
   } delta_word_type;

   typedef struct packed {
      logic [5:0]        body_b;
      logic [5:0]        body_a;
      logic signed [31:0] pen;
      logic signed [31:0] em;
      logic [VEC_W-1:0]  jla;
      logic [VEC_W-1:0]  jaa;
      logic [VEC_W-1:0]  jlb;
      logic [VEC_W-1:0]  jab;
   } cst_word_type;

   function automatic logic signed [COMP_W-1:0] vcomp(input logic [VEC_W-1:0] v,
                                                     input logic [1:0] k);
      vcomp = v[COMP_W*k +: COMP_W];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647)
         sat32 = 32'sh7fffffff;
      else if (x < -64'sd2147483648)
         sat32 = 32'sh80000000;
      else
         sat32 = x[31:0];
   endfunction

   function automatic logic signed [COMP_W-1:0] sat21(input logic signed [63:0] x);
      if (x > 64'sd1048575)
         sat21 = 21'sh0fffff;
      else if (x < -64'sd1048576)
         sat21 = 21'sh100000;
      else
         sat21 = x[COMP_W-1:0];
   endfunction

endpackage

@@ rtl/contact_position_projection_solver.sv @@
// ----------------------------------------------------------------------------
// contact_position_projection_solver
// Projected Gauss-Seidel position correction over stored bodies and contacts.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  req_*     in         one action: load body, load constraint, solve, read
//  rsp_*     out        status and, on a read, the body's packed deltas
//  APB       in/out     control registers slop .. island_asleep
//
//  Load and read: one RAM port access each.
//  Solve: a clearing sweep over max(MAX_BODIES, MAX_CONSTRAINTS) entries, then per
//  pass and constraint a read and check (skipped constraints end there), the
//  dot product and residual (inactive ones end there), the lambda update (ends
//  there when lambda does not move), and the push of both bodies.
//  After reset the same sweep zeroes deltas and lambdas before req_ready rises.
//  A waiting response does not block acceptance of the next transaction.
// ----------------------------------------------------------------------------
module contact_position_projection_solver
   import cpps_pkg::*;
#(
   parameter int MAX_BODIES      = CPPS_MAX_BODIES,
   parameter int MAX_CONSTRAINTS = CPPS_MAX_CONSTRAINTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  logic [5:0]       req_slot,
   input  logic [5:0]       req_body_a,
   input  logic [5:0]       req_body_b,
   input  logic signed [31:0] req_penetration,
   input  logic signed [31:0] req_effective_mass,
   input  logic [VEC_W-1:0] req_jac_lin_a,
   input  logic [VEC_W-1:0] req_jac_ang_a,
   input  logic [VEC_W-1:0] req_jac_lin_b,
   input  logic [VEC_W-1:0] req_jac_ang_b,
   input  logic [30:0]      req_inverse_mass,
   input  logic [VEC_W-1:0] req_inv_inertia,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_status,
   output logic [VEC_W-1:0] rsp_delta_linear,
   output logic [VEC_W-1:0] rsp_delta_angular,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int BAW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CAW = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
   localparam int NBW = $clog2(MAX_BODIES + 1);
   localparam int CCW = $clog2(MAX_CONSTRAINTS + 1);
   localparam int CLR_DEPTH = (MAX_BODIES > MAX_CONSTRAINTS) ? MAX_BODIES : MAX_CONSTRAINTS;
   localparam int CLW = $clog2(CLR_DEPTH + 1);

   typedef enum logic [4:0] {
      S_RCLR, S_IDLE, S_RDWAIT, S_OUT, S_SCLR,
      S_C_RD, S_C_CHK, S_D_A, S_D_B, S_DOT, S_RES, S_EMUL, S_LAM,
      S_P_RD, S_P_S1, S_P_S2, S_P_K1, S_P_K2, S_P_K3, S_P_WR, S_NEXT
   } state_type;

   // control registers
   logic [30:0] slop_ff;
   logic [4:0]  iterations_ff;
   logic [6:0]  ccount_ff;
   logic [6:0]  bcount_ff;
   logic        asleep_ff;

   state_type          state_ff;
   logic [CLW-1:0]     clr_ff;
   logic [CCW-1:0]     cidx_ff;
   logic [4:0]         iter_ff;
   logic signed [32:0] phi_ff;
   logic [BAW-1:0]     a_ff, b_ff;
   delta_word_type     da_ff, db_ff, dnew_ff;
   logic [3:0]         dcnt_ff;
   logic signed [41:0] prod_ff;
   logic signed [44:0] acc_ff;
   logic signed [31:0] res_ff;
   logic signed [63:0] mprod_ff;
   logic signed [31:0] dl_ff;
   logic signed [31:0] s_ff;
   logic               side_ff;
   logic [1:0]         kcnt_ff;
   logic signed [52:0] m1_ff;
   logic signed [41:0] m2_ff;
   logic signed [61:0] m3_ff;
   logic               pend_status_ff;
   logic [VEC_W-1:0]   pend_lin_ff, pend_ang_ff;
   logic               rsp_valid_ff;
   logic               rsp_status_ff;
   logic [VEC_W-1:0]   rsp_lin_ff, rsp_ang_ff;

   // RAM ports
   logic                body_we, body_re;
   logic [BAW-1:0]      body_waddr, body_raddr;
   body_word_type       body_wdata, body_q;
   logic [$bits(body_word_type)-1:0] body_rdata;

   logic                cst_we, cst_re;
   logic [CAW-1:0]      cst_waddr, cst_raddr;
   cst_word_type        cst_wdata, cst_q;
   logic [$bits(cst_word_type)-1:0] cst_rdata;

   logic                dl_we, dl_re;
   logic [BAW-1:0]      dl_waddr, dl_raddr;
   delta_word_type      dl_wdata, dl_q;
   logic [$bits(delta_word_type)-1:0] dl_rdata;

   logic                lam_we, lam_re;
   logic [CAW-1:0]      lam_waddr, lam_raddr;
   logic signed [31:0]  lam_wdata, lam_q;

   logic [NBW-1:0] nb;
   logic [CCW-1:0] nc;
   logic           body_ok, cst_ok;
   logic [BAW-1:0] ca_in, cb_in, px;
   logic           cst_live_in;
   logic signed [32:0] phi_in;
   logic signed [31:0] res_in, dl_in, nl_in, dlam_in, s_in;
   logic signed [COMP_W-1:0] jop, dop, lin_in, ang_in;
   logic [1:0] dk;
   logic [VEC_W-1:0] pjl, pja;
   logic last_c, last_it;

   assign body_q = body_rdata;
   assign cst_q  = cst_rdata;
   assign dl_q   = dl_rdata;

   // ------------------------------------------------------------------ config
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slop_ff       <= SLOP_RESET;
         iterations_ff <= ITERATIONS_RESET;
         ccount_ff     <= CCOUNT_RESET;
         bcount_ff     <= BCOUNT_RESET;
         asleep_ff     <= 1'b0;
      end else if (psel && penable && pwrite) begin
         case (reg_index_type'(paddr[4:2]))
            REG_SLOP:       slop_ff       <= pwdata[30:0];
            REG_ITERATIONS: iterations_ff <= pwdata[4:0];
            REG_CCOUNT:     ccount_ff     <= pwdata[6:0];
            REG_BCOUNT:     bcount_ff     <= pwdata[6:0];
            REG_ASLEEP:     asleep_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[4:2]))
         REG_SLOP:       prdata = {1'b0, slop_ff};
         REG_ITERATIONS: prdata = {27'd0, iterations_ff};
         REG_CCOUNT:     prdata = {25'd0, ccount_ff};
         REG_BCOUNT:     prdata = {25'd0, bcount_ff};
         REG_ASLEEP:     prdata = {31'd0, asleep_ff};
         default:        prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ combinational
   assign nb = (bcount_ff < MAX_BODIES) ? NBW'(bcount_ff) : NBW'(MAX_BODIES);
   assign nc = (ccount_ff < MAX_CONSTRAINTS) ? CCW'(ccount_ff) : CCW'(MAX_CONSTRAINTS);
   assign body_ok = req_slot < nb;
   assign cst_ok  = req_slot < MAX_CONSTRAINTS;

   assign ca_in  = BAW'(cst_q.body_a);
   assign cb_in  = BAW'(cst_q.body_b);
   assign phi_in = 33'(cst_q.pen) - $signed({2'b00, slop_ff});
   assign cst_live_in = !phi_in[32] && (phi_in != '0) &&
                        (cst_q.body_a < nb) && (cst_q.body_b < nb);

   assign res_in  = sat32(64'(phi_ff) - 64'(acc_ff >>> 8));
   assign dl_in   = sat32(mprod_ff >>> 16);
   always_comb begin
      nl_in = sat32(64'(lam_q) + 64'(dl_in));
      if (nl_in[31])
         nl_in = '0;
   end
   assign dlam_in = nl_in - lam_q;
   assign s_in    = sat32(mprod_ff >>> 16);

   // dot product operand order: per component, lin A, ang A, lin B, ang B
   assign dk = dcnt_ff[3:2];
   always_comb begin
      case (dcnt_ff[1:0])
         2'd0:    begin jop = vcomp(cst_q.jla, dk); dop = vcomp(da_ff.lin, dk); end
         2'd1:    begin jop = vcomp(cst_q.jaa, dk); dop = vcomp(da_ff.ang, dk); end
         2'd2:    begin jop = vcomp(cst_q.jlb, dk); dop = vcomp(db_ff.lin, dk); end
         default: begin jop = vcomp(cst_q.jab, dk); dop = vcomp(db_ff.ang, dk); end
      endcase
   end

   assign px  = side_ff ? b_ff : a_ff;
   assign pjl = side_ff ? cst_q.jlb : cst_q.jla;
   assign pja = side_ff ? cst_q.jab : cst_q.jaa;
   assign lin_in = sat21(64'(vcomp(dnew_ff.lin, kcnt_ff)) + 64'(m1_ff >>> 16));
   assign ang_in = sat21(64'(vcomp(dnew_ff.ang, kcnt_ff)) + 64'(m3_ff >>> 16));

   assign last_c  = (cidx_ff + 1'b1) == nc;
   assign last_it = (iter_ff + 1'b1) == iterations_ff;

   // ---------------------------------------------------------- memory control
   always_comb begin
      body_we = 1'b0; body_re = 1'b0;
      body_waddr = BAW'(req_slot); body_raddr = px;
      body_wdata = '{inverse_mass: req_inverse_mass, inertia: req_inv_inertia};
      cst_we = 1'b0; cst_re = 1'b0;
      cst_waddr = CAW'(req_slot); cst_raddr = CAW'(cidx_ff);
      cst_wdata = '{body_b: req_body_b, body_a: req_body_a, pen: req_penetration,
                    em: req_effective_mass, jla: req_jac_lin_a, jaa: req_jac_ang_a,
                    jlb: req_jac_lin_b, jab: req_jac_ang_b};
      dl_we = 1'b0; dl_re = 1'b0;
      dl_waddr = px; dl_raddr = px; dl_wdata = dnew_ff;
      lam_we = 1'b0; lam_re = 1'b0;
      lam_waddr = CAW'(cidx_ff); lam_raddr = CAW'(cidx_ff); lam_wdata = nl_in;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (action_type'(req_action))
                  ACT_LOAD_BODY: body_we = body_ok;
                  ACT_LOAD_CST:  cst_we  = cst_ok;
                  ACT_READ: begin
                     dl_re    = body_ok;
                     dl_raddr = BAW'(req_slot);
                  end
                  default: ;
               endcase
            end
         end
         S_RCLR, S_SCLR: begin
            dl_we     = clr_ff < MAX_BODIES;
            dl_waddr  = BAW'(clr_ff);
            dl_wdata  = '0;
            lam_we    = clr_ff < MAX_CONSTRAINTS;
            lam_waddr = CAW'(clr_ff);
            lam_wdata = '0;
         end
         S_C_RD: begin
            cst_re = 1'b1;
            lam_re = 1'b1;
         end
         S_C_CHK: begin
            dl_re    = cst_live_in;
            dl_raddr = ca_in;
         end
         S_D_A: begin
            dl_re    = 1'b1;
            dl_raddr = b_ff;
         end
         S_LAM:  lam_we = 1'b1;
         S_P_RD: begin
            body_re = 1'b1;
            dl_re   = 1'b1;
         end
         S_P_WR: dl_we = 1'b1;
         default: ;
      endcase
   end

   // --------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RCLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_RCLR, S_SCLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLW'(CLR_DEPTH - 1)) begin
                  if (state_ff == S_RCLR) begin
                     state_ff <= S_IDLE;
                  end else if (asleep_ff || iterations_ff == '0 || nc == '0) begin
                     pend_status_ff <= 1'b0;
                     state_ff       <= S_OUT;
                  end else begin
                     cidx_ff  <= '0;
                     iter_ff  <= '0;
                     state_ff <= S_C_RD;
                  end
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  pend_lin_ff <= '0;
                  pend_ang_ff <= '0;
                  case (action_type'(req_action))
                     ACT_LOAD_BODY: begin
                        pend_status_ff <= !body_ok;
                        state_ff       <= S_OUT;
                     end
                     ACT_LOAD_CST: begin
                        pend_status_ff <= !cst_ok;
                        state_ff       <= S_OUT;
                     end
                     ACT_SOLVE: begin
                        pend_status_ff <= (nb == '0);
                        if (nb == '0) begin
                           state_ff <= S_OUT;
                        end else begin
                           clr_ff   <= '0;
                           state_ff <= S_SCLR;
                        end
                     end
                     ACT_READ: begin
                        pend_status_ff <= !body_ok;
                        state_ff       <= body_ok ? S_RDWAIT : S_OUT;
                     end
                     default: begin
                        pend_status_ff <= 1'b0;
                        state_ff       <= S_OUT;
                     end
                  endcase
               end
            end
            S_RDWAIT: begin
               pend_lin_ff <= dl_q.lin;
               pend_ang_ff <= dl_q.ang;
               state_ff    <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= pend_status_ff;
                  rsp_lin_ff    <= pend_lin_ff;
                  rsp_ang_ff    <= pend_ang_ff;
                  state_ff      <= S_IDLE;
               end
            end
            S_C_RD: state_ff <= S_C_CHK;
            S_C_CHK: begin
               phi_ff <= phi_in;
               a_ff   <= ca_in;
               b_ff   <= cb_in;
               state_ff <= cst_live_in ? S_D_A : S_NEXT;
            end
            S_D_A: begin
               da_ff    <= dl_q;
               state_ff <= S_D_B;
            end
            S_D_B: begin
               db_ff    <= dl_q;
               dcnt_ff  <= '0;
               acc_ff   <= '0;
               state_ff <= S_DOT;
            end
            S_DOT: begin
               // multiply one term while the previous one is accumulated
               if (dcnt_ff != 4'd12)
                  prod_ff <= jop * dop;
               if (dcnt_ff != '0)
                  acc_ff <= acc_ff + 45'(prod_ff);
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == 4'd12)
                  state_ff <= S_RES;
            end
            S_RES: begin
               res_ff   <= res_in;
               state_ff <= S_EMUL;
            end
            S_EMUL: begin
               if (res_ff[31] || res_ff == '0 || cst_q.em[31] || cst_q.em == '0) begin
                  state_ff <= S_NEXT;
               end else begin
                  mprod_ff <= cst_q.em * res_ff;
                  state_ff <= S_LAM;
               end
            end
            S_LAM: begin
               dl_ff   <= dlam_in;
               side_ff <= 1'b0;
               state_ff <= (dlam_in == '0) ? S_NEXT : S_P_RD;
            end
            S_P_RD: state_ff <= S_P_S1;
            S_P_S1: begin
               mprod_ff <= $signed({1'b0, body_q.inverse_mass}) * dl_ff;
               dnew_ff  <= dl_q;
               kcnt_ff  <= '0;
               state_ff <= S_P_S2;
            end
            S_P_S2: begin
               s_ff     <= s_in;
               state_ff <= S_P_K1;
            end
            S_P_K1: begin
               m1_ff    <= vcomp(pjl, kcnt_ff) * s_ff;
               m2_ff    <= vcomp(body_q.inertia, kcnt_ff) * vcomp(pja, kcnt_ff);
               state_ff <= S_P_K2;
            end
            S_P_K2: begin
               dnew_ff.lin[COMP_W*kcnt_ff +: COMP_W] <= lin_in;
               m3_ff    <= (m2_ff >>> 12) * dl_ff;
               state_ff <= S_P_K3;
            end
            S_P_K3: begin
               dnew_ff.ang[COMP_W*kcnt_ff +: COMP_W] <= ang_in;
               kcnt_ff <= kcnt_ff + 1'b1;
               state_ff <= (kcnt_ff == 2'd2) ? S_P_WR : S_P_K1;
            end
            S_P_WR: begin
               if (!side_ff) begin
                  side_ff  <= 1'b1;
                  state_ff <= S_P_RD;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (last_c) begin
                  cidx_ff <= '0;
                  iter_ff <= iter_ff + 1'b1;
               end else begin
                  cidx_ff <= cidx_ff + 1'b1;
               end
               if (last_c && last_it) begin
                  pend_status_ff <= 1'b0;
                  state_ff       <= S_OUT;
               end else begin
                  state_ff <= S_C_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready         = state_ff == S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_delta_linear  = rsp_lin_ff;
   assign rsp_delta_angular = rsp_ang_ff;

   // --------------------------------------------------------------- memories
   cpps_ram #(.WIDTH($bits(body_word_type)), .DEPTH(MAX_BODIES)) u_body_ram (
      .clock(clock), .we(body_we), .waddr(body_waddr), .wdata(body_wdata),
      .re(body_re), .raddr(body_raddr), .rdata(body_rdata)
   );

   cpps_ram #(.WIDTH($bits(cst_word_type)), .DEPTH(MAX_CONSTRAINTS)) u_cst_ram (
      .clock(clock), .we(cst_we), .waddr(cst_waddr), .wdata(cst_wdata),
      .re(cst_re), .raddr(cst_raddr), .rdata(cst_rdata)
   );

   cpps_ram #(.WIDTH($bits(delta_word_type)), .DEPTH(MAX_BODIES)) u_delta_ram (
      .clock(clock), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
      .re(dl_re), .raddr(dl_raddr), .rdata(dl_rdata)
   );

   cpps_ram #(.WIDTH(32), .DEPTH(MAX_CONSTRAINTS)) u_lambda_ram (
      .clock(clock), .we(lam_we), .waddr(lam_waddr), .wdata(lam_wdata),
      .re(lam_re), .raddr(lam_raddr), .rdata(lam_q)
   );

endmodule

@@ rtl/cpps_ram.sv @@
// ----------------------------------------------------------------------------
// cpps_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we)
         mem[waddr] <= wdata;
      if (re)
         rdata <= mem[raddr];
   end

endmodule
